// ----- rtl/core/dome_azimuth_positioner_defines.svh -----
// Assertion macros shared by the dome azimuth positioner.
`ifndef DOME_AZIMUTH_POSITIONER_DEFINES_SVH
`define DOME_AZIMUTH_POSITIONER_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define DAP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, implies another at the following edge.
`define DAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dap_pkg.sv -----
// Types, codes and helper functions for the dome azimuth positioner.
package dap_pkg;

    localparam int AngleWidth = 9;
    localparam int SpeedWidth = 8;

    localparam logic [AngleWidth-1:0] FullTurn = 9'd360;
    localparam logic [AngleWidth-1:0] HalfTurn = 9'd180;

    localparam logic [2:0] ModeTick  = 3'd0;
    localparam logic [2:0] ModeGoto  = 3'd1;
    localparam logic [2:0] ModeSteps = 3'd2;
    localparam logic [2:0] ModePark  = 3'd3;
    localparam logic [2:0] ModeAbort = 3'd4;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StBusy  = 2'd1;
    localparam logic [1:0] StAlert = 2'd2;

    typedef struct packed {
        logic [2:0]            mode;
        logic [AngleWidth-1:0] goal_azimuth;
        logic [AngleWidth-1:0] step_amount;
        logic                  step_direction;
        logic                  park_wanted;
    } cmd_t;

    typedef struct packed {
        logic [AngleWidth-1:0] position;
        logic [AngleWidth-1:0] target;
        logic                  direction;
        logic [AngleWidth-1:0] steps;
        logic [1:0]            motion_st;
        logic [1:0]            steps_st;
        logic                  parking;
        logic                  parked;
    } state_t;

    // Reduces a value below twice a full turn into 0 to 359.
    function automatic logic [AngleWidth-1:0] wrap_turn(input logic [AngleWidth:0] value);
        logic [AngleWidth:0] reduced;
        begin
            reduced = value - {1'b0, FullTurn};
            if (value >= {1'b0, FullTurn})
            begin
                wrap_turn = reduced[AngleWidth-1:0];
            end
            else
            begin
                wrap_turn = value[AngleWidth-1:0];
            end
        end
    endfunction

    // Clockwise distance from a to b, both in 0 to 359.
    function automatic logic [AngleWidth-1:0] cw_distance(input logic [AngleWidth-1:0] a,
                                                          input logic [AngleWidth-1:0] b);
        logic [AngleWidth:0] sum;
        begin
            sum = {1'b0, b} + {1'b0, FullTurn} - {1'b0, a};
            cw_distance = wrap_turn(sum);
        end
    endfunction

endpackage

// ----- rtl/core/dap_next_state.sv -----
// Next-state logic: applies one command to the positioner state.
module dap_next_state
(
    input  dap_pkg::cmd_t                   cmd,
    input  dap_pkg::state_t                 state,
    input  logic [dap_pkg::SpeedWidth-1:0]  speed,
    output dap_pkg::state_t                 state_next
);

    logic [dap_pkg::AngleWidth-1:0] goal_wrapped;
    logic [dap_pkg::AngleWidth-1:0] amount_wrapped;
    logic [dap_pkg::AngleWidth-1:0] goto_dist;
    logic [dap_pkg::AngleWidth-1:0] tick_dist;
    logic [dap_pkg::AngleWidth-1:0] pos_fwd;
    logic [dap_pkg::AngleWidth-1:0] pos_back;
    logic [dap_pkg::AngleWidth-1:0] steps_fwd;
    logic [dap_pkg::AngleWidth-1:0] steps_back;
    logic [dap_pkg::AngleWidth:0]   speed_ext;

    assign speed_ext      = {{(dap_pkg::AngleWidth + 1 - dap_pkg::SpeedWidth){1'b0}}, speed};
    assign goal_wrapped   = dap_pkg::wrap_turn({1'b0, cmd.goal_azimuth});
    assign amount_wrapped = dap_pkg::wrap_turn({1'b0, cmd.step_amount});
    assign goto_dist      = dap_pkg::cw_distance(state.position, goal_wrapped);
    assign tick_dist      = state.direction ? dap_pkg::cw_distance(state.target, state.position)
                                            : dap_pkg::cw_distance(state.position, state.target);
    assign pos_fwd        = dap_pkg::wrap_turn({1'b0, state.position} + speed_ext);
    assign pos_back       = dap_pkg::wrap_turn({1'b0, state.position} + {1'b0, dap_pkg::FullTurn}
                                               - speed_ext);
    assign steps_fwd      = dap_pkg::wrap_turn({1'b0, state.position} + {1'b0, amount_wrapped});
    assign steps_back     = dap_pkg::wrap_turn({1'b0, state.position} + {1'b0, dap_pkg::FullTurn}
                                               - {1'b0, amount_wrapped});

    always_comb
    begin
        state_next = state;
        unique case (cmd.mode)
            dap_pkg::ModeTick:
            begin
                if (state.motion_st == dap_pkg::StAlert)
                begin
                    state_next.target   = state.position;
                    state_next.steps_st = dap_pkg::StAlert;
                end
                else if (state.position != state.target)
                begin
                    state_next.motion_st = dap_pkg::StBusy;
                    state_next.steps_st  = dap_pkg::StBusy;
                    if ({1'b0, tick_dist} > speed_ext)
                    begin
                        state_next.position = state.direction ? pos_back : pos_fwd;
                    end
                    else
                    begin
                        state_next.position = state.target;
                    end
                end
                else
                begin
                    state_next.motion_st = dap_pkg::StOk;
                    state_next.steps_st  = dap_pkg::StOk;
                    state_next.parking   = 1'b0;
                end
            end
            dap_pkg::ModeGoto:
            begin
                if (state.parked)
                begin
                    state_next.motion_st = dap_pkg::StAlert;
                end
                else
                begin
                    state_next.target = goal_wrapped;
                    if (goto_dist < dap_pkg::HalfTurn)
                    begin
                        state_next.direction = 1'b0;
                        state_next.steps     = goto_dist;
                    end
                    else if (goto_dist > dap_pkg::HalfTurn)
                    begin
                        state_next.direction = 1'b1;
                        state_next.steps     = dap_pkg::FullTurn - goto_dist;
                    end
                    state_next.motion_st = dap_pkg::StBusy;
                    state_next.steps_st  = dap_pkg::StBusy;
                end
            end
            dap_pkg::ModeSteps:
            begin
                if (state.parked)
                begin
                    state_next.steps_st = dap_pkg::StAlert;
                end
                else
                begin
                    state_next.steps     = amount_wrapped;
                    state_next.direction = cmd.step_direction;
                    state_next.target    = cmd.step_direction ? steps_back : steps_fwd;
                    state_next.motion_st = dap_pkg::StBusy;
                    state_next.steps_st  = dap_pkg::StBusy;
                end
            end
            dap_pkg::ModePark:
            begin
                state_next.parked  = cmd.park_wanted;
                state_next.parking = cmd.park_wanted;
                if (cmd.park_wanted)
                begin
                    if (state.position > dap_pkg::HalfTurn)
                    begin
                        state_next.direction = 1'b0;
                        state_next.steps     = dap_pkg::FullTurn - state.position;
                    end
                    else if (state.position < dap_pkg::HalfTurn)
                    begin
                        state_next.direction = 1'b1;
                        state_next.steps     = state.position;
                    end
                    state_next.target    = '0;
                    state_next.motion_st = dap_pkg::StBusy;
                    state_next.steps_st  = dap_pkg::StBusy;
                end
            end
            dap_pkg::ModeAbort:
            begin
                if (state.motion_st == dap_pkg::StBusy)
                begin
                    state_next.motion_st = dap_pkg::StAlert;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

// ----- rtl/core/dome_azimuth_positioner.sv -----
// Top level of the dome azimuth positioner: command register, state and result register.
// The positioner takes one command item per clock cycle while the output side is ready
// and returns one result item for each. A command first lands in an input register; the
// next-state logic then applies it combinationally to the dome state, and the state
// register itself is the result register, so the result always shows the state after
// that command. A stalled output holds the result and at most one further command waits
// in the input register. The speed register resets to one degree per tick and is written
// through the configuration channel, which is always ready.
`include "dome_azimuth_positioner_defines.svh"

module dome_azimuth_positioner
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,       // speed_degrees
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // goal_azimuth, step_amount, step_direction, park_wanted
    input  logic [2:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // azimuth_now, azimuth_goal, turn_direction,
                                        // planned_steps, motion_status, steps_status,
                                        // park_busy, is_parked
);

    logic                            in_valid_reg;
    dap_pkg::cmd_t                   cmd_reg;
    dap_pkg::cmd_t                   cmd_in;
    logic                            out_valid_reg;
    dap_pkg::state_t                 state_reg;
    dap_pkg::state_t                 state_next;
    logic [dap_pkg::SpeedWidth-1:0]  speed_reg;
    logic                            advance;
    logic                            in_take;

    assign cmd_in.mode           = s_axis_tuser;
    assign cmd_in.goal_azimuth   = s_axis_tdata[8:0];
    assign cmd_in.step_amount    = s_axis_tdata[17:9];
    assign cmd_in.step_direction = s_axis_tdata[18];
    assign cmd_in.park_wanted    = s_axis_tdata[19];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    dap_next_state u_next_state
    (
        .cmd        (cmd_reg),
        .state      (state_reg),
        .speed      (speed_reg),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            speed_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            state_reg     <= state_next;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid       = out_valid_reg;
    assign m_axis_tdata[8:0]   = state_reg.position;
    assign m_axis_tdata[17:9]  = state_reg.target;
    assign m_axis_tdata[18]    = state_reg.direction;
    assign m_axis_tdata[27:19] = state_reg.steps;
    assign m_axis_tdata[29:28] = state_reg.motion_st;
    assign m_axis_tdata[31:30] = state_reg.steps_st;
    assign m_axis_tdata[32]    = state_reg.parking;
    assign m_axis_tdata[33]    = state_reg.parked;
    assign m_axis_tdata[39:34] = 6'd0;

    `DAP_ASSERT_ALWAYS(a_position_range, state_reg.position < dap_pkg::FullTurn, "Azimuth out of range.")
    `DAP_ASSERT_ALWAYS(a_parking_parked, !state_reg.parking || state_reg.parked, "Parking while not parked.")
    `DAP_ASSERT_NEXT(a_advance_result, advance, out_valid_reg, "Applied command gave no result.")
    `DAP_ASSERT_NEXT(a_cmd_held, in_valid_reg && !advance, in_valid_reg, "Waiting command was lost.")

endmodule

// ----- tb/sv/dome_azimuth_positioner_tb.sv -----
// Self-checking testbench for the dome azimuth positioner with a predictor of the dome state.
`timescale 1ns / 100ps

module dome_azimuth_positioner_tb;

    localparam int FullDeg = int'(dap_pkg::FullTurn);
    localparam int HalfDeg = int'(dap_pkg::HalfTurn);
    localparam logic [2:0] ModeUnusedLo = 3'd5;
    localparam logic [2:0] ModeUnusedHi = 3'd7;
    localparam int DrainCycles = 4;
    localparam int LongHoldCycles = 300;
    localparam int PhaseItems = 470;
    localparam int ChunkItems = 120;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;       // speed_degrees
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // goal_azimuth, step_amount, step_direction, park_wanted
    logic [2:0]  s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // azimuth_now, azimuth_goal, turn_direction, planned_steps,
                                 // motion_status, steps_status, park_busy, is_parked

    logic [7:0]        speed_setting;
    dap_pkg::state_t   dome;
    dap_pkg::state_t   expected_states[$];

    int sender_idle_pct;
    int receiver_idle_pct;
    int items_sent;
    int results_checked;
    int mismatch_count;
    int speeds_written;
    int hold_count;
    bit hold_wanted;
    bit hold_served;

    dome_azimuth_positioner i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    function automatic int clockwise_arc(input int origin, input int dest);
        begin
            clockwise_arc = (dest + FullDeg - origin) % FullDeg;
        end
    endfunction

    // Applies one command to the predicted dome state and returns the state that follows.
    function automatic dap_pkg::state_t apply_command(input dap_pkg::cmd_t c);
        int pos;
        int goal;
        int amount;
        int speed;
        int arc;
        begin
            pos = int'(dome.position);
            goal = int'(c.goal_azimuth) % FullDeg;
            amount = int'(c.step_amount) % FullDeg;
            speed = int'(speed_setting);
            unique case (c.mode)
                dap_pkg::ModeTick:
                begin
                    if (dome.motion_st == dap_pkg::StAlert)
                    begin
                        dome.target = dome.position;
                        dome.steps_st = dap_pkg::StAlert;
                    end
                    else if (dome.position != dome.target)
                    begin
                        if (dome.direction == 1'b0)
                        begin
                            arc = clockwise_arc(pos, int'(dome.target));
                            dome.position = (arc > speed) ? 9'((pos + speed) % FullDeg)
                                                          : dome.target;
                        end
                        else
                        begin
                            arc = clockwise_arc(int'(dome.target), pos);
                            dome.position = (arc > speed) ? 9'((pos + FullDeg - speed) % FullDeg)
                                                          : dome.target;
                        end
                        dome.motion_st = dap_pkg::StBusy;
                        dome.steps_st = dap_pkg::StBusy;
                    end
                    else
                    begin
                        dome.motion_st = dap_pkg::StOk;
                        dome.steps_st = dap_pkg::StOk;
                        dome.parking = 1'b0;
                    end
                end
                dap_pkg::ModeGoto:
                begin
                    if (dome.parked)
                    begin
                        dome.motion_st = dap_pkg::StAlert;
                    end
                    else
                    begin
                        dome.target = 9'(goal);
                        arc = clockwise_arc(pos, goal);
                        if (arc < HalfDeg)
                        begin
                            dome.direction = 1'b0;
                            dome.steps = 9'(arc);
                        end
                        else if (arc > HalfDeg)
                        begin
                            dome.direction = 1'b1;
                            dome.steps = 9'(FullDeg - arc);
                        end
                        dome.motion_st = dap_pkg::StBusy;
                        dome.steps_st = dap_pkg::StBusy;
                    end
                end
                dap_pkg::ModeSteps:
                begin
                    if (dome.parked)
                    begin
                        dome.steps_st = dap_pkg::StAlert;
                    end
                    else
                    begin
                        dome.steps = 9'(amount);
                        dome.direction = c.step_direction;
                        dome.target = c.step_direction ? 9'((pos + FullDeg - amount) % FullDeg) :
                                                         9'((pos + amount) % FullDeg);
                        dome.motion_st = dap_pkg::StBusy;
                        dome.steps_st = dap_pkg::StBusy;
                    end
                end
                dap_pkg::ModePark:
                begin
                    dome.parking = 1'b0;
                    dome.parked = c.park_wanted;
                    if (c.park_wanted)
                    begin
                        dome.parking = 1'b1;
                        if (pos > HalfDeg)
                        begin
                            dome.direction = 1'b0;
                            dome.steps = 9'(FullDeg - pos);
                        end
                        else if (pos < HalfDeg)
                        begin
                            dome.direction = 1'b1;
                            dome.steps = dome.position;
                        end
                        dome.target = '0;
                        dome.motion_st = dap_pkg::StBusy;
                        dome.steps_st = dap_pkg::StBusy;
                    end
                end
                dap_pkg::ModeAbort:
                begin
                    if (dome.motion_st == dap_pkg::StBusy)
                    begin
                        dome.motion_st = dap_pkg::StAlert;
                    end
                end
                default:
                begin
                end
            endcase
            apply_command = dome;
        end
    endfunction

    function automatic dap_pkg::cmd_t build_cmd(input logic [2:0] mode, input logic [8:0] goal,
                                                input logic [8:0] amount, input logic dir,
                                                input logic wanted);
        begin
            build_cmd.mode = mode;
            build_cmd.goal_azimuth = goal;
            build_cmd.step_amount = amount;
            build_cmd.step_direction = dir;
            build_cmd.park_wanted = wanted;
        end
    endfunction

    function automatic logic [8:0] random_angle();
        begin
            random_angle = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(FullDeg, 511)) :
                                                          9'($urandom_range(0, FullDeg - 1));
        end
    endfunction

    function automatic dap_pkg::cmd_t random_tick();
        begin
            random_tick = build_cmd(dap_pkg::ModeTick, 9'($urandom_range(0, 511)),
                                    9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
        end
    endfunction

    function automatic dap_pkg::cmd_t random_command();
        int pick;
        begin
            pick = $urandom_range(0, 99);
            random_command = random_tick();
            random_command.goal_azimuth = random_angle();
            random_command.step_amount = random_angle();
            if (pick < 35)
                random_command.mode = dap_pkg::ModeGoto;
            else if (pick < 60)
                random_command.mode = dap_pkg::ModeSteps;
            else if (pick < 75)
                random_command.mode = dap_pkg::ModePark;
            else if (pick < 88)
                random_command.mode = dap_pkg::ModeAbort;
            else if (pick < 95)
                random_command.mode = dap_pkg::ModeTick;
            else
                random_command.mode = 3'($urandom_range(ModeUnusedLo, ModeUnusedHi));
        end
    endfunction

    task automatic report_mismatch(input string what);
        begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatch_count++;
        end
    endtask

    task automatic check_field(input string name, input int seen, input int wanted);
        begin
            if (seen != wanted)
                report_mismatch($sformatf("result %0d %s is %0d, predicted %0d",
                                          results_checked, name, seen, wanted));
        end
    endtask

    // Sends one command item; the prediction is made at the edge where it is accepted.
    task automatic send_command(input dap_pkg::cmd_t c);
        int gap;
        begin
            if ($urandom_range(0, 99) < sender_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                gap = $urandom_range(1, 4);
                repeat (gap) @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {4'b0, c.park_wanted, c.step_direction, c.step_amount,
                             c.goal_azimuth};
            s_axis_tuser <= c.mode;
            do
                @(posedge clk);
            while (!s_axis_tready);
            expected_states.push_back(apply_command(c));
            items_sent++;
            @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        begin
            s_axis_tvalid <= 1'b0;
            while (expected_states.size() != 0)
                @(negedge clk);
            repeat (DrainCycles) @(negedge clk);
        end
    endtask

    task automatic set_speed(input logic [7:0] value);
        begin
            wait_idle();
            cfg_valid <= 1'b1;
            cfg_data <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            speed_setting = value;
            speeds_written++;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic test_directed_commands();
        begin
            sender_idle_pct = 23;
            receiver_idle_pct = 84;
            send_command(build_cmd(dap_pkg::ModeTick, 9'h1FF, 9'h1FF, 1'b1, 1'b1));
            send_command(build_cmd(dap_pkg::ModeGoto, 9'd180, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeAbort, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeAbort, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeGoto, 9'd359, 9'd0, 1'b0, 1'b0));
            repeat (3) send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeGoto, 9'h1FF, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeSteps, 9'd0, 9'h1FF, 1'b1, 1'b0));
            send_command(build_cmd(dap_pkg::ModeSteps, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeSteps, 9'd0, 9'd359, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModePark, 9'd0, 9'd0, 1'b0, 1'b1));
            send_command(build_cmd(dap_pkg::ModeGoto, 9'd10, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeSteps, 9'd0, 9'd5, 1'b1, 1'b0));
            send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModePark, 9'd0, 9'd0, 1'b0, 1'b0));
            for (int m = int'(ModeUnusedLo); m <= int'(ModeUnusedHi); m++)
                send_command(build_cmd(3'(m), 9'h1FF, 9'h1FF, 1'b1, 1'b1));
            send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeAbort, 9'd0, 9'd0, 1'b0, 1'b0));
        end
    endtask

    // A goto exactly half a turn away, and a park from exactly half a turn, keep the old direction and planned steps.
    task automatic test_half_turn_cases();
        begin
            set_speed(8'd180);
            send_command(build_cmd(dap_pkg::ModeGoto,
                                   9'((int'(dome.position) + HalfDeg) % FullDeg), 9'd0,
                                   1'b0, 1'b0));
            repeat (2) send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeGoto, 9'd180, 9'd0, 1'b0, 1'b0));
            repeat (3) send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModePark, 9'd0, 9'd0, 1'b0, 1'b1));
            repeat (3) send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModePark, 9'd0, 9'd0, 1'b0, 1'b0));
        end
    endtask

    // At zero speed a pending move never completes; at full scale a move of up to 255 degrees snaps at once.
    task automatic test_speed_extremes();
        begin
            set_speed(8'd0);
            send_command(build_cmd(dap_pkg::ModeSteps, 9'd0, 9'd10, 1'b0, 1'b0));
            repeat (3) send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeAbort, 9'd0, 9'd0, 1'b0, 1'b0));
            send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
            set_speed(8'd255);
            send_command(build_cmd(dap_pkg::ModeSteps, 9'd0, 9'd300, 1'b1, 1'b0));
            repeat (3) send_command(build_cmd(dap_pkg::ModeTick, 9'd0, 9'd0, 1'b0, 1'b0));
        end
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        int phase_end;
        int chunk_end;
        int ticks;
        begin
            phase_end = items_sent + PhaseItems;
            while (items_sent < phase_end)
            begin
                case ($urandom_range(0, 5))
                    0: set_speed(8'd1);
                    1: set_speed(8'd180);
                    2: set_speed(8'd255);
                    3: set_speed(8'd0);
                    default: set_speed(8'($urandom_range(2, 179)));
                endcase
                sender_idle_pct = sender_pct;
                receiver_idle_pct = receiver_pct;
                chunk_end = items_sent + ChunkItems;
                while (items_sent < chunk_end && items_sent < phase_end)
                begin
                    send_command(random_command());
                    ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) :
                                                          $urandom_range(0, 8);
                    repeat (ticks) send_command(random_tick());
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        begin
            set_speed(8'($urandom_range(1, 180)));
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
            hold_wanted = 1'b1;
            repeat (10)
            begin
                send_command(random_command());
                repeat (2) send_command(random_tick());
            end
        end
    endtask

    // The receiver stalls at random, and once for a long stretch when the hold is requested.
    always
    begin
        @(negedge clk);
        if (hold_wanted && !hold_served)
        begin
            m_axis_tready <= 1'b0;
            hold_count = 0;
            while (hold_count < LongHoldCycles)
            begin
                @(negedge clk);
                hold_count++;
            end
            hold_served = 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        dap_pkg::state_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_states.size() == 0)
            begin
                report_mismatch($sformatf("result with no command outstanding, data %h",
                                          m_axis_tdata));
            end
            else
            begin
                want = expected_states.pop_front();
                check_field("azimuth_now", int'(m_axis_tdata[8:0]), int'(want.position));
                check_field("azimuth_goal", int'(m_axis_tdata[17:9]), int'(want.target));
                check_field("turn_direction", int'(m_axis_tdata[18]), int'(want.direction));
                check_field("planned_steps", int'(m_axis_tdata[27:19]), int'(want.steps));
                check_field("motion_status", int'(m_axis_tdata[29:28]), int'(want.motion_st));
                check_field("steps_status", int'(m_axis_tdata[31:30]), int'(want.steps_st));
                check_field("park_busy", int'(m_axis_tdata[32]), int'(want.parking));
                check_field("is_parked", int'(m_axis_tdata[33]), int'(want.parked));
            end
            results_checked++;
        end
    end

    initial
    begin
        #400000;
        $display("Timeout with %0d results outstanding", expected_states.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int waited;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = dap_pkg::ModeTick;
        m_axis_tready = 1'b0;
        speed_setting = 8'd1;
        dome = '0;
        items_sent = 0;
        results_checked = 0;
        mismatch_count = 0;
        speeds_written = 0;
        hold_wanted = 1'b0;
        hold_served = 1'b0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_commands();
        test_half_turn_cases();
        test_speed_extremes();
        test_random_traffic(23, 84);
        test_random_traffic(84, 23);
        test_random_traffic(0, 0);
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_states.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);
        if (expected_states.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_states.size()));

        $display("Covered %0d commands and %0d results over %0d speed settings, from 0 to 255.",
                 items_sent, results_checked, speeds_written);
        $display("Output held off for %0d cycles once; %0d mismatches found.",
                 LongHoldCycles, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dap_pkg.sv
rtl/core/dap_next_state.sv
rtl/core/dome_azimuth_positioner.sv
tb/sv/dome_azimuth_positioner_tb.sv
